[hdl/acs_pkg.sv]
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, constants and the microcode table of the admittance step.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int STEP_W    = 4;
  localparam int DIV_STEPS = 32;

  localparam logic [31:0] S32_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN  = 32'h8000_0000;
  localparam logic [16:0] DT_RESET = 17'd66;

  // configuration register indexes
  localparam logic [1:0] CFG_MASS      = 2'd0;
  localparam logic [1:0] CFG_DAMPING   = 2'd1;
  localparam logic [1:0] CFG_STIFFNESS = 2'd2;
  localparam logic [1:0] CFG_TIME_STEP = 2'd3;

  // microprogram step addresses
  localparam logic [STEP_W-1:0] STEP_FETCH  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_ERR    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SUB_D  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SUB_K  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DIV    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DIVW   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MUL_A  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_ADD_V  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_SAT_V  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_SUM    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_MUL_S  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_ADD_X  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_COMMIT = 4'd12;
  localparam logic [STEP_W-1:0] STEP_CLEAR  = 4'd13;
  localparam logic [STEP_W-1:0] STEP_LAST   = 4'd13;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_ERR,
    ACC_SUB,
    ACC_ADD,
    ACC_LOAD_V,
    ACC_LOAD_X,
    ACC_VSUM
  } acc_sel_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DV,
    MUL_KX,
    MUL_QT,
    MUL_ST
  } mul_sel_e;

  typedef enum logic [1:0] {
    H_NONE,
    H_NO_REQ,
    H_DIV_BUSY,
    H_OUT_FULL
  } hold_e;

  typedef enum logic [1:0] {
    B_NEXT,
    B_CLEAR,
    B_ALWAYS
  } br_e;

  typedef struct packed {
    logic              accept;
    hold_e             hold;
    br_e               br;
    logic [STEP_W-1:0] target;
    acc_sel_e          acc_sel;
    mul_sel_e          mul_sel;
    logic              sh1;
    logic              div_start;
    logic              vn_load;
    logic              commit;
    logic              clear;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic kind;
    logic div_busy;
    logic out_full;
  } seq_status_t;

  localparam ctrl_word_t CW_NOP = '{
    accept:    1'b0,
    hold:      H_NONE,
    br:        B_NEXT,
    target:    STEP_FETCH,
    acc_sel:   ACC_HOLD,
    mul_sel:   MUL_NONE,
    sh1:       1'b0,
    div_start: 1'b0,
    vn_load:   1'b0,
    commit:    1'b0,
    clear:     1'b0
  };

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // microcode table
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = CW_NOP;
    case (step)
      STEP_FETCH: begin
        cw.accept = 1'b1;
        cw.hold   = H_NO_REQ;
      end
      STEP_ERR: begin
        cw.acc_sel = ACC_ERR;
        cw.mul_sel = MUL_DV;
        cw.br      = B_CLEAR;
        cw.target  = STEP_CLEAR;
      end
      STEP_SUB_D: begin
        cw.acc_sel = ACC_SUB;
        cw.mul_sel = MUL_KX;
      end
      STEP_SUB_K: begin
        cw.acc_sel = ACC_SUB;
      end
      STEP_DIV: begin
        cw.div_start = 1'b1;
      end
      STEP_DIVW: begin
        cw.hold = H_DIV_BUSY;
      end
      STEP_MUL_A: begin
        cw.mul_sel = MUL_QT;
        cw.acc_sel = ACC_LOAD_V;
      end
      STEP_ADD_V: begin
        cw.acc_sel = ACC_ADD;
      end
      STEP_SAT_V: begin
        cw.vn_load = 1'b1;
      end
      STEP_SUM: begin
        cw.acc_sel = ACC_VSUM;
      end
      STEP_MUL_S: begin
        cw.mul_sel = MUL_ST;
        cw.acc_sel = ACC_LOAD_X;
      end
      STEP_ADD_X: begin
        cw.acc_sel = ACC_ADD;
        cw.sh1     = 1'b1;
      end
      STEP_COMMIT: begin
        cw.commit = 1'b1;
        cw.hold   = H_OUT_FULL;
        cw.br     = B_ALWAYS;
        cw.target = STEP_FETCH;
      end
      STEP_CLEAR: begin
        cw.clear  = 1'b1;
        cw.hold   = H_OUT_FULL;
        cw.br     = B_ALWAYS;
        cw.target = STEP_FETCH;
      end
      default: begin
        cw.br     = B_ALWAYS;
        cw.target = STEP_FETCH;
      end
    endcase
    return cw;
  endfunction

endpackage

[hdl/admittance_control_step.sv]
// ----------------------------------------------------------------------------
// admittance_control_step
// One-axis admittance controller (mass-spring-damper) in signed fixed point.
// ----------------------------------------------------------------------------
// One request at a time. An update request runs from acceptance through the
// 32-iteration serial divider that forms the acceleration to the result being
// presented; when the numerator is zero or the quotient does not fit 32 bits,
// the divider finishes at once. A clear request runs only the error and clear
// steps. The next request can be accepted in the cycle the result is presented,
// also while that result still waits on the output; its own result is held back
// until that one is taken. Configuration writes are accepted in every cycle and
// must only be issued while the block is idle.
module admittance_control_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic signed [31:0] force_desired_i,
  input  logic signed [31:0] force_measured_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] position_command_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int          AW         = 65 - FRAC_BITS;
  localparam logic [30:0] MASS_RESET = 31'(1) << FRAC_BITS;

  logic [30:0] mass_q;
  logic [31:0] damping_q;
  logic [31:0] stiffness_q;
  logic [16:0] time_step_q;

  acs_pkg::ctrl_word_t  cw;
  acs_pkg::seq_status_t status;
  logic                 fire;
  logic                 kind_q;
  logic                 out_full;
  logic                 div_busy;
  logic [31:0]          quot;
  logic [AW-1:0]        div_num;
  logic [31:0]          pos_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q      <= MASS_RESET;
      damping_q   <= '0;
      stiffness_q <= '0;
      time_step_q <= acs_pkg::DT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        acs_pkg::CFG_MASS:      mass_q      <= cfg_data_i[30:0];
        acs_pkg::CFG_DAMPING:   damping_q   <= cfg_data_i;
        acs_pkg::CFG_STIFFNESS: stiffness_q <= cfg_data_i;
        acs_pkg::CFG_TIME_STEP: time_step_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  assign status.in_valid = in_valid_i;
  assign status.kind     = kind_q;
  assign status.div_busy = div_busy;
  assign status.out_full = out_full;

  acs_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cw_o     (cw),
    .fire_o   (fire)
  );

  acs_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fire && cw.div_start),
    .num_i   (div_num),
    .den_i   (mass_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  acs_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cw_i               (cw),
    .fire_i             (fire),
    .in_valid_i         (in_valid_i),
    .kind_i             (kind_i),
    .force_desired_i    (force_desired_i),
    .force_measured_i   (force_measured_i),
    .damping_i          (damping_q),
    .stiffness_i        (stiffness_q),
    .time_step_i        (time_step_q),
    .quot_i             (quot),
    .div_num_o          (div_num),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .position_command_o (pos_cmd),
    .kind_o             (kind_q),
    .out_full_o         (out_full)
  );

  assign in_ready_o         = cw.accept;
  assign position_command_o = pos_cmd;

endmodule

[hdl/acs_sequencer.sv]
// ----------------------------------------------------------------------------
// acs_sequencer
// Step counter over the microcode table with wait and branch conditions.
// ----------------------------------------------------------------------------
module acs_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  acs_pkg::seq_status_t status_i,
  output acs_pkg::ctrl_word_t  cw_o,
  output logic                 fire_o
);

  logic [acs_pkg::STEP_W-1:0] step_q, step_d;
  acs_pkg::ctrl_word_t cw;
  logic hold;

  always_comb begin
    cw = acs_pkg::ucode(step_q);
    case (cw.hold)
      acs_pkg::H_NONE:     hold = 1'b0;
      acs_pkg::H_NO_REQ:   hold = !status_i.in_valid;
      acs_pkg::H_DIV_BUSY: hold = status_i.div_busy;
      acs_pkg::H_OUT_FULL: hold = status_i.out_full;
      default:             hold = 1'b0;
    endcase
    if (hold) begin
      step_d = step_q;
    end else begin
      case (cw.br)
        acs_pkg::B_NEXT:   step_d = step_q + 1'b1;
        acs_pkg::B_CLEAR:  step_d = status_i.kind ? cw.target : step_q + 1'b1;
        acs_pkg::B_ALWAYS: step_d = cw.target;
        default:           step_d = acs_pkg::STEP_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= acs_pkg::STEP_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign cw_o   = cw;
  assign fire_o = !hold;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= acs_pkg::STEP_LAST)
    else $error("step counter left the program");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_busy |-> step_q == acs_pkg::STEP_DIVW)
    else $error("divider busy outside its wait step");

  a_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == acs_pkg::STEP_COMMIT && status_i.out_full) |=>
    step_q == acs_pkg::STEP_COMMIT)
    else $error("commit step left while result still pending");
`endif

endmodule

[hdl/acs_divider.sv]
// ----------------------------------------------------------------------------
// acs_divider
// Serial restoring divider: (num << FRAC_BITS) / den, toward zero, saturated.
// ----------------------------------------------------------------------------
module acs_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [64-FRAC_BITS:0]  num_i,
  input  logic [30:0]            den_i,
  output logic                   busy_o,
  output logic [31:0]            quot_o
);

  localparam int AW    = 65 - FRAC_BITS;
  localparam int MAG_W = AW - 1;
  localparam int CNT_W = $clog2(acs_pkg::DIV_STEPS);

  logic [MAG_W-1:0] mag;
  logic [63:0]      dvd;
  logic             ovf;
  logic             neg_q;
  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [30:0]      rem_q;
  logic [31:0]      sh_q;
  logic [31:0]      quot_q;
  logic [31:0]      trial;
  logic             ge;
  logic [31:0]      q_fin;
  logic [31:0]      q_sat;

  assign mag = num_i[AW-1] ? MAG_W'(~num_i + 1'b1) : num_i[MAG_W-1:0];
  assign dvd = {mag, {FRAC_BITS{1'b0}}};
  // quotient does not fit 32 bits
  assign ovf = dvd[63:32] >= {1'b0, den_i};

  assign trial = {rem_q, sh_q[31]};
  assign ge    = trial >= {1'b0, den_i};
  assign q_fin = {sh_q[30:0], ge};

  always_comb begin
    if (neg_q) begin
      q_sat = (q_fin > acs_pkg::S32_MIN) ? acs_pkg::S32_MIN : q_fin;
    end else begin
      q_sat = q_fin[31] ? acs_pkg::S32_MAX : q_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= (mag != '0) && !ovf;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(acs_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[AW-1];
      rem_q <= dvd[62:32];
      sh_q  <= dvd[31:0];
      if (mag == '0) begin
        quot_q <= '0;
      end else if (ovf) begin
        quot_q <= num_i[AW-1] ? acs_pkg::S32_MIN : acs_pkg::S32_MAX;
      end
    end else if (busy_q) begin
      rem_q <= ge ? 31'(trial - {1'b0, den_i}) : trial[30:0];
      sh_q  <= q_fin;
      if (cnt_q == CNT_W'(acs_pkg::DIV_STEPS - 1)) begin
        quot_q <= neg_q ? (~q_sat + 32'd1) : q_sat;
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

[hdl/acs_datapath.sv]
// ----------------------------------------------------------------------------
// acs_datapath
// Accumulator, shared multiplier, state registers and result register.
// ----------------------------------------------------------------------------
module acs_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  acs_pkg::ctrl_word_t   cw_i,
  input  logic                  fire_i,
  input  logic                  in_valid_i,
  input  logic                  kind_i,
  input  logic [31:0]           force_desired_i,
  input  logic [31:0]           force_measured_i,
  input  logic [31:0]           damping_i,
  input  logic [31:0]           stiffness_i,
  input  logic [16:0]           time_step_i,
  input  logic [31:0]           quot_i,
  output logic [64-FRAC_BITS:0] div_num_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [31:0]           position_command_o,
  output logic                  kind_o,
  output logic                  out_full_o
);

  localparam int AW = 65 - FRAC_BITS;

  logic [31:0]   fd_q, fm_q;
  logic          kind_q;
  logic [AW-1:0] acc_q, acc_d;
  logic [64:0]   prod_q;
  logic          pneg_q;
  logic [31:0]   x_q, v_q, vn_q;
  logic [31:0]   pos_q;
  logic          out_valid_q;

  logic [32:0]   mul_a;
  logic [31:0]   mul_b;
  logic          mul_neg;
  logic [AW-1:0] acc_mag;
  logic [64:0]   prod_sh;
  logic [AW-1:0] pterm;
  logic [31:0]   acc_sat;

  function automatic logic [AW-1:0] sx(input logic [31:0] v);
    return {{(AW-32){v[31]}}, v};
  endfunction

  assign acc_mag = acc_q[AW-1] ? (~acc_q + 1'b1) : acc_q;

  // operand select for the shared multiplier
  always_comb begin
    case (cw_i.mul_sel)
      acs_pkg::MUL_DV: begin
        mul_a   = {1'b0, acs_pkg::abs32(damping_i)};
        mul_b   = acs_pkg::abs32(v_q);
        mul_neg = damping_i[31] ^ v_q[31];
      end
      acs_pkg::MUL_KX: begin
        mul_a   = {1'b0, acs_pkg::abs32(stiffness_i)};
        mul_b   = acs_pkg::abs32(x_q);
        mul_neg = stiffness_i[31] ^ x_q[31];
      end
      acs_pkg::MUL_QT: begin
        mul_a   = {1'b0, acs_pkg::abs32(quot_i)};
        mul_b   = 32'(time_step_i);
        mul_neg = quot_i[31];
      end
      acs_pkg::MUL_ST: begin
        mul_a   = acc_mag[32:0];
        mul_b   = 32'(time_step_i);
        mul_neg = acc_q[AW-1];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  // product truncated toward zero, the trapezoid term takes one more halving
  assign prod_sh = cw_i.sh1 ? (prod_q >> (FRAC_BITS + 1)) : (prod_q >> FRAC_BITS);
  assign pterm   = pneg_q ? (~{1'b0, prod_sh[AW-2:0]} + 1'b1) : {1'b0, prod_sh[AW-2:0]};

  always_comb begin
    case (cw_i.acc_sel)
      acs_pkg::ACC_HOLD:   acc_d = acc_q;
      acs_pkg::ACC_ERR:    acc_d = sx(fd_q) - sx(fm_q);
      acs_pkg::ACC_SUB:    acc_d = acc_q - pterm;
      acs_pkg::ACC_ADD:    acc_d = acc_q + pterm;
      acs_pkg::ACC_LOAD_V: acc_d = sx(v_q);
      acs_pkg::ACC_LOAD_X: acc_d = sx(x_q);
      acs_pkg::ACC_VSUM:   acc_d = sx(v_q) + sx(vn_q);
      default:             acc_d = acc_q;
    endcase
  end

  // saturate the accumulator to the signed 32-bit range
  always_comb begin
    if ((&acc_q[AW-1:31]) || !(|acc_q[AW-1:31])) begin
      acc_sat = acc_q[31:0];
    end else if (acc_q[AW-1]) begin
      acc_sat = acs_pkg::S32_MIN;
    end else begin
      acc_sat = acs_pkg::S32_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && cw_i.accept && in_valid_i) begin
      fd_q   <= force_desired_i;
      fm_q   <= force_measured_i;
      kind_q <= kind_i;
    end
    if (fire_i) begin
      acc_q  <= acc_d;
      prod_q <= 65'(mul_a) * 65'(mul_b);
      pneg_q <= mul_neg;
    end
    if (fire_i && cw_i.vn_load) begin
      vn_q <= acc_sat;
    end
    if (fire_i && cw_i.commit) begin
      pos_q <= acc_sat;
    end else if (fire_i && cw_i.clear) begin
      pos_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire_i && cw_i.commit) begin
        x_q         <= acc_sat;
        v_q         <= vn_q;
        out_valid_q <= 1'b1;
      end else if (fire_i && cw_i.clear) begin
        x_q         <= '0;
        v_q         <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign div_num_o          = acc_q;
  assign out_valid_o        = out_valid_q;
  assign position_command_o = pos_q;
  assign kind_o             = kind_q;
  assign out_full_o         = out_valid_q;

endmodule
